/* hw/rtl/flp_pkg.sv */
// shared types, constants and microcode program of the frame pacing limiter
package flp_pkg;

    // behavior constants
    localparam int unsigned LAG_FRAMES    = 3;
    localparam int unsigned COMPILE_GRACE = 32;
    localparam logic signed [20:0] USEC_PER_SEC = 21'sd1000000;
    localparam logic [30:0] SCALED_SEC    = 31'd1024000000;
    localparam logic [19:0] SLEEP_MAX     = 20'hFFFFF;

    // datapath widths
    localparam int unsigned IV_W     = 18;
    localparam int unsigned ISC_W    = 28;
    localparam int unsigned DUS_W    = 30;
    localparam int unsigned SEC_W    = 32;
    localparam int unsigned USEC_W   = 20;
    localparam int unsigned PROD_W   = 53;
    localparam int unsigned LEAD_W   = 56;
    localparam int unsigned LAG_W    = IV_W + $clog2(LAG_FRAMES + 1);
    localparam int unsigned TGT_W    = 22;
    localparam int unsigned DIV_BITS = USEC_W;
    localparam int unsigned CNT_W    = $clog2(DIV_BITS);
    localparam int unsigned RUN_W    = $clog2(COMPILE_GRACE + 1);
    localparam int unsigned PC_W     = 4;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 28;

    localparam logic [IV_W-1:0]  RST_INTERVAL_USEC   = 18'd16667;
    localparam logic [ISC_W-1:0] RST_INTERVAL_SCALED = 28'd17066667;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERVAL_USEC   = 3'd0,
        CFG_INTERVAL_SCALED = 3'd1,
        CFG_VSYNC_PHASE     = 3'd2,
        CFG_LIMIT_ENABLE    = 3'd3,
        CFG_SKIP_ENABLE     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [IV_W-1:0]  interval_usec;
        logic [ISC_W-1:0] interval_scaled;
        logic [IV_W-1:0]  vsync_phase_usec;
        logic             limit_enable;
        logic             skip_enable;
    } flp_cfg_t;

    // channel payloads
    typedef struct packed {
        logic [SEC_W-1:0]  now_sec;
        logic [USEC_W-1:0] now_usec;
        logic              recompiled;
    } flp_in_t;

    typedef struct packed {
        logic [USEC_W-1:0] sleep_usec;
        logic              skip_advice;
        logic              resynced;
    } flp_out_t;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ADV_SUM,
        OP_ADV_WRAP,
        OP_DIFF,
        OP_MUL,
        OP_LEAD,
        OP_CHECK,
        OP_TARGET,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_RESYNC,
        OP_SLEEP,
        OP_ADVICE,
        OP_DONE
    } dp_op_t;

    // jump conditions of the sequencer
    typedef enum logic [2:0] {
        JMP_NEVER,
        JMP_ALWAYS,
        JMP_NO_START,
        JMP_IN_RANGE,
        JMP_NO_TAKE,
        JMP_LOOP,
        JMP_OUT_BUSY
    } jmp_cond_t;

    typedef struct packed {
        dp_op_t          op;
        jmp_cond_t       cond;
        logic [PC_W-1:0] target;
        logic            cnt_load;
    } ucode_word_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic out_of_range;
        logic take;
    } dp_flags_t;

    // sequencer control toward datapath and top
    typedef struct packed {
        dp_op_t op;
        logic   idle;
    } seq_ctrl_t;

    // program labels
    localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV    = 4'd10;
    localparam logic [PC_W-1:0] PC_RESYNC = 4'd11;
    localparam logic [PC_W-1:0] PC_SLEEP  = 4'd12;
    localparam logic [PC_W-1:0] PC_DONE   = 4'd14;

    // control store
    function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_word_t w;
        case (pc)
            4'd0:  w = '{OP_NOP,      JMP_NO_START, PC_IDLE,   1'b0};
            4'd1:  w = '{OP_ADV_SUM,  JMP_NEVER,    PC_IDLE,   1'b0};
            4'd2:  w = '{OP_ADV_WRAP, JMP_NEVER,    PC_IDLE,   1'b0};
            4'd3:  w = '{OP_DIFF,     JMP_NEVER,    PC_IDLE,   1'b0};
            4'd4:  w = '{OP_MUL,      JMP_NEVER,    PC_IDLE,   1'b0};
            4'd5:  w = '{OP_LEAD,     JMP_NEVER,    PC_IDLE,   1'b0};
            4'd6:  w = '{OP_CHECK,    JMP_NEVER,    PC_IDLE,   1'b0};
            4'd7:  w = '{OP_TARGET,   JMP_IN_RANGE, PC_SLEEP,  1'b0};
            4'd8:  w = '{OP_DIV_INIT, JMP_NEVER,    PC_IDLE,   1'b1};
            4'd9:  w = '{OP_NOP,      JMP_NO_TAKE,  PC_RESYNC, 1'b0};
            4'd10: w = '{OP_DIV_STEP, JMP_LOOP,     PC_DIV,    1'b0};
            4'd11: w = '{OP_RESYNC,   JMP_NEVER,    PC_IDLE,   1'b0};
            4'd12: w = '{OP_SLEEP,    JMP_NEVER,    PC_IDLE,   1'b0};
            4'd13: w = '{OP_ADVICE,   JMP_NEVER,    PC_IDLE,   1'b0};
            4'd14: w = '{OP_DONE,     JMP_OUT_BUSY, PC_DONE,   1'b0};
            default: w = '{OP_NOP,    JMP_ALWAYS,   PC_IDLE,   1'b0};
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/flp_seq.sv */
// microcode sequencer: step counter, control store and loop counter
module flp_seq
    import flp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      out_busy,
    input  dp_flags_t flags,
    output seq_ctrl_t ctrl
);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    ucode_word_t      word;
    logic             jump;

    // fetch, branch decision and loop count
    always_comb begin
        word = ucode_rom(pc_reg);
        case (word.cond)
            JMP_NEVER:    jump = 1'b0;
            JMP_ALWAYS:   jump = 1'b1;
            JMP_NO_START: jump = !start;
            JMP_IN_RANGE: jump = !flags.out_of_range;
            JMP_NO_TAKE:  jump = !flags.take;
            JMP_LOOP:     jump = (cnt_reg != '0);
            JMP_OUT_BUSY: jump = out_busy;
            default:      jump = 1'b0;
        endcase
        pc_next  = jump ? word.target : PC_W'(pc_reg + 1'b1);
        cnt_next = cnt_reg;
        if (word.cnt_load) begin
            cnt_next = CNT_W'(DIV_BITS - 1);
        end else if (word.cond == JMP_LOOP && cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.idle = (pc_reg == PC_IDLE);

    // the divide loop only exits once all quotient bits are done
    a_div_exit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == PC_DIV && pc_next != PC_DIV) |-> (cnt_reg == '0))
        else $error("divide loop left early");

endmodule

/* hw/rtl/flp_dpath.sv */
// pacing datapath: deadline state, lead arithmetic, phase divider, advice
module flp_dpath
    import flp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_op_t    op,
    input  logic      load,
    input  flp_in_t   in_data,
    input  flp_cfg_t  cfg,
    output dp_flags_t flags,
    output flp_out_t  result
);

    // architectural state
    logic [SEC_W-1:0] ds_reg, ds_next;
    logic [DUS_W-1:0] dus_reg, dus_next;
    logic             advice_reg, advice_next;
    logic [RUN_W-1:0] run_reg, run_next;

    // captured transaction
    logic [SEC_W-1:0]  now_sec_reg;
    logic [USEC_W-1:0] now_usec_reg;
    logic              recompiled_reg;

    // working registers
    logic [DUS_W:0]           sum_reg, sum_next;
    logic [SEC_W-1:0]         sdiff_reg, sdiff_next;
    logic [LAG_W-1:0]         lag_reg, lag_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [LEAD_W-1:0] lead_reg, lead_next;
    logic signed [TGT_W-1:0]  target_reg, target_next;
    logic [DIV_BITS-1:0]      dvd_reg, dvd_next;
    logic [IV_W-1:0]          rem_reg, rem_next;
    logic [USEC_W-1:0]        sleep_reg, sleep_next;
    logic                     oor_reg, oor_next;
    logic                     take_reg, take_next;
    logic                     resync_reg, resync_next;

    // helper terms
    logic signed [LEAD_W-1:0] iv_s, lag_s, sleep_max_s, sleep_diff, lead_plus_iv;
    logic signed [TGT_W-1:0]  phase_s;
    logic [IV_W:0]            trial, trial_diff;

    assign iv_s         = LEAD_W'($signed({1'b0, cfg.interval_usec}));
    assign lag_s        = LEAD_W'($signed({1'b0, lag_reg}));
    assign sleep_max_s  = LEAD_W'($signed({1'b0, SLEEP_MAX}));
    assign sleep_diff   = lead_reg - iv_s;
    assign lead_plus_iv = lead_reg + iv_s;
    assign phase_s      = TGT_W'($signed({1'b0, cfg.vsync_phase_usec}));
    assign trial        = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign trial_diff   = trial - {1'b0, cfg.interval_usec};

    // micro-operation decode
    always_comb begin
        ds_next     = ds_reg;
        dus_next    = dus_reg;
        advice_next = advice_reg;
        run_next    = run_reg;
        sum_next    = sum_reg;
        sdiff_next  = sdiff_reg;
        lag_next    = lag_reg;
        prod_next   = prod_reg;
        lead_next   = lead_reg;
        target_next = target_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        sleep_next  = sleep_reg;
        oor_next    = oor_reg;
        take_next   = take_reg;
        resync_next = resync_reg;
        case (op)
            // advance deadline by one scaled interval
            OP_ADV_SUM: begin
                sum_next    = {1'b0, dus_reg} + (DUS_W + 1)'(cfg.interval_scaled);
                resync_next = 1'b0;
            end
            // carry into seconds
            OP_ADV_WRAP: begin
                if (sum_reg >= SCALED_SEC) begin
                    dus_next = DUS_W'(sum_reg - SCALED_SEC);
                    ds_next  = ds_reg + 1'b1;
                end else begin
                    dus_next = sum_reg[DUS_W-1:0];
                end
            end
            OP_DIFF: begin
                sdiff_next = ds_reg - now_sec_reg;
                lag_next   = LAG_W'(cfg.interval_usec) * LAG_W'(LAG_FRAMES);
            end
            OP_MUL: begin
                prod_next = $signed(sdiff_reg) * USEC_PER_SEC;
            end
            OP_LEAD: begin
                lead_next = LEAD_W'(prod_reg)
                          + LEAD_W'($signed({1'b0, dus_reg[DUS_W-1:10]}))
                          - LEAD_W'($signed({1'b0, now_usec_reg}));
            end
            OP_CHECK: begin
                oor_next = (lead_reg > lag_s) || (lead_reg < -lag_s);
            end
            OP_TARGET: begin
                target_next = TGT_W'($signed({1'b0, now_usec_reg}))
                            - TGT_W'($signed({1'b0, cfg.interval_usec}));
            end
            // remainder of (target - phase - 1) by the interval sets the phase
            OP_DIV_INIT: begin
                take_next = (cfg.interval_usec != '0) && (phase_s < target_reg);
                dvd_next  = DIV_BITS'(target_reg - phase_s - TGT_W'(1));
                rem_next  = '0;
            end
            OP_DIV_STEP: begin
                if (!trial_diff[IV_W]) begin
                    rem_next = trial_diff[IV_W-1:0];
                end else begin
                    rem_next = trial[IV_W-1:0];
                end
                dvd_next = {dvd_reg[DIV_BITS-2:0], 1'b0};
            end
            // realign deadline to now on the vsync phase grid
            OP_RESYNC: begin
                ds_next = now_sec_reg;
                if (take_reg) begin
                    dus_next = {now_usec_reg - USEC_W'(1) - USEC_W'(rem_reg), 10'b0};
                end else begin
                    dus_next = {2'b00, cfg.vsync_phase_usec, 10'b0};
                end
                lead_next   = '0;
                resync_next = 1'b1;
            end
            OP_SLEEP: begin
                if (cfg.limit_enable && sleep_diff > 0) begin
                    sleep_next = (sleep_diff > sleep_max_s) ? SLEEP_MAX
                                                            : sleep_diff[USEC_W-1:0];
                end else begin
                    sleep_next = '0;
                end
            end
            OP_ADVICE: begin
                if (cfg.skip_enable) begin
                    if (lead_plus_iv[LEAD_W-1]) begin
                        advice_next = 1'b1;
                    end else if (!lead_reg[LEAD_W-1]) begin
                        advice_next = 1'b0;
                    end
                    if (recompiled_reg) begin
                        if (run_reg < RUN_W'(COMPILE_GRACE)) begin
                            advice_next = 1'b0;
                            run_next    = run_reg + 1'b1;
                        end
                    end else begin
                        run_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ds_reg     <= '0;
            dus_reg    <= '0;
            advice_reg <= 1'b0;
            run_reg    <= '0;
            oor_reg    <= 1'b0;
            take_reg   <= 1'b0;
            resync_reg <= 1'b0;
        end else begin
            ds_reg     <= ds_next;
            dus_reg    <= dus_next;
            advice_reg <= advice_next;
            run_reg    <= run_next;
            oor_reg    <= oor_next;
            take_reg   <= take_next;
            resync_reg <= resync_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (load) begin
            now_sec_reg    <= in_data.now_sec;
            now_usec_reg   <= in_data.now_usec;
            recompiled_reg <= in_data.recompiled;
        end
        sum_reg    <= sum_next;
        sdiff_reg  <= sdiff_next;
        lag_reg    <= lag_next;
        prod_reg   <= prod_next;
        lead_reg   <= lead_next;
        target_reg <= target_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        sleep_reg  <= sleep_next;
    end

    assign flags.out_of_range = oor_reg;
    assign flags.take         = take_reg;

    assign result.sleep_usec  = sleep_reg;
    assign result.skip_advice = advice_reg;
    assign result.resynced    = resync_reg;

endmodule

/* hw/rtl/frame_pacing_limiter_core.sv */
// frame pacing limiter top level: handshakes, configuration registers, output register
// flow: an accepted transaction advances the deadline and checks the lead range;
//   out of range it resyncs, with the 20-step phase remainder loop on a phase step
// the microcode sequencer runs one transaction at a time, and the phase divider loop is
//   the longest path; a finished result waits while the output register is full
// reset: synchronous active-low aresetn clears deadline, advice and run count and
//   loads the configuration defaults; no channel is ready while reset is held
module frame_pacing_limiter_core
    import flp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  flp_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output flp_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    flp_cfg_t  cfg_reg, cfg_next;
    seq_ctrl_t ctrl;
    dp_flags_t flags;
    flp_out_t  result;
    flp_out_t  out_reg;
    logic      m_valid_reg, m_valid_next;
    logic      in_acc, out_busy, out_load;

    assign in_acc    = s_valid && s_ready;
    assign s_ready   = ctrl.idle && aresetn;
    assign cfg_ready = aresetn;
    assign out_busy  = m_valid_reg && !m_ready;
    assign out_load  = (ctrl.op == OP_DONE) && !out_busy;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_INTERVAL_USEC:   cfg_next.interval_usec    = cfg_data[IV_W-1:0];
                CFG_INTERVAL_SCALED: cfg_next.interval_scaled  = cfg_data[ISC_W-1:0];
                CFG_VSYNC_PHASE:     cfg_next.vsync_phase_usec = cfg_data[IV_W-1:0];
                CFG_LIMIT_ENABLE:    cfg_next.limit_enable     = cfg_data[0];
                CFG_SKIP_ENABLE:     cfg_next.skip_enable      = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval_usec    <= RST_INTERVAL_USEC;
            cfg_reg.interval_scaled  <= RST_INTERVAL_SCALED;
            cfg_reg.vsync_phase_usec <= '0;
            cfg_reg.limit_enable     <= 1'b1;
            cfg_reg.skip_enable      <= 1'b0;
            m_valid_reg              <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    flp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    flp_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (ctrl.op),
        .load    (in_acc),
        .in_data (s_data),
        .cfg     (cfg_reg),
        .flags   (flags),
        .result  (result)
    );

    // one transaction in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    // a resynced deadline has zero lead, so no sleep
    a_resync_no_sleep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.resynced && m_data.sleep_usec != '0))
        else $error("sleep reported on a resynced frame");

    // a result is only written into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data))
        else $error("pending result overwritten");

endmodule
